// ===== rtl/b2v_pkg.sv =====
// Shared widths, queue entry and queue status types for the barycentric block.
`timescale 1ns / 1ps
package b2v_pkg;

  localparam int COORD_W    = 32;
  localparam int TOL_W      = 16;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int CROSS_W    = PROD_W + 1;
  localparam int QB         = COORD_W + 1;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = 2;
  localparam int CNT_W      = 3;

  // One classified triangle query waiting for the divide pipeline
  typedef struct packed {
    logic signed [CROSS_W-1:0] det;
    logic signed [CROSS_W-1:0] num_a;
    logic signed [CROSS_W-1:0] num_b;
    logic signed [CROSS_W-1:0] num_c;
    logic                      degen;
  } b2v_entry_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } b2v_fifo_stat_t;

endpackage

// ===== rtl/b2v_front.sv =====
// Front end: accept transactions, form the edge products and classify degenerate triangles.
`timescale 1ns / 1ps
module b2v_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [31:0]            in_vert_a_s,
  input  logic signed [31:0]            in_vert_a_t,
  input  logic signed [31:0]            in_vert_b_s,
  input  logic signed [31:0]            in_vert_b_t,
  input  logic signed [31:0]            in_vert_c_s,
  input  logic signed [31:0]            in_vert_c_t,
  input  logic signed [31:0]            in_point_s,
  input  logic signed [31:0]            in_point_t,
  input  b2v_pkg::b2v_fifo_stat_t       fifo_stat,
  output logic                          push,
  output b2v_pkg::b2v_entry_t           push_entry
);
  import b2v_pkg::*;

  function automatic logic signed [DIFF_W-1:0] sdiff(input logic signed [COORD_W-1:0] x,
                                                     input logic signed [COORD_W-1:0] y);
    return DIFF_W'(x) - DIFF_W'(y);
  endfunction

  logic v1_r, v2_r;
  logic adv;
  logic signed [DIFF_W-1:0] ba_s_r, ba_t_r, ca_s_r, ca_t_r;
  logic signed [DIFF_W-1:0] ap_s_r, ap_t_r, bp_s_r, bp_t_r, cp_s_r, cp_t_r;
  logic signed [PROD_W-1:0] prod_r [8];

  // Advance the whole front unless its last stage is blocked by a full queue
  assign adv      = !(v2_r && fifo_stat.full);
  assign in_ready = adv;
  assign push     = v2_r && !fifo_stat.full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  // Edge vectors relative to vertex a and to the query point
  always_ff @(posedge clk) begin
    if (adv) begin
      ba_s_r <= sdiff(in_vert_b_s, in_vert_a_s);
      ba_t_r <= sdiff(in_vert_b_t, in_vert_a_t);
      ca_s_r <= sdiff(in_vert_c_s, in_vert_a_s);
      ca_t_r <= sdiff(in_vert_c_t, in_vert_a_t);
      ap_s_r <= sdiff(in_vert_a_s, in_point_s);
      ap_t_r <= sdiff(in_vert_a_t, in_point_t);
      bp_s_r <= sdiff(in_vert_b_s, in_point_s);
      bp_t_r <= sdiff(in_vert_b_t, in_point_t);
      cp_s_r <= sdiff(in_vert_c_s, in_point_s);
      cp_t_r <= sdiff(in_vert_c_t, in_point_t);
    end
  end

  // Cross product terms, one multiplier per term
  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r[0] <= ba_s_r * ca_t_r;
      prod_r[1] <= ca_s_r * ba_t_r;
      prod_r[2] <= bp_s_r * cp_t_r;
      prod_r[3] <= cp_s_r * bp_t_r;
      prod_r[4] <= cp_s_r * ap_t_r;
      prod_r[5] <= ap_s_r * cp_t_r;
      prod_r[6] <= ap_s_r * bp_t_r;
      prod_r[7] <= bp_s_r * ap_t_r;
    end
  end

  // Form determinant and numerators; a zero determinant means equal terms
  always_comb begin
    push_entry.det   = CROSS_W'(prod_r[0]) - CROSS_W'(prod_r[1]);
    push_entry.num_a = CROSS_W'(prod_r[2]) - CROSS_W'(prod_r[3]);
    push_entry.num_b = CROSS_W'(prod_r[4]) - CROSS_W'(prod_r[5]);
    push_entry.num_c = CROSS_W'(prod_r[6]) - CROSS_W'(prod_r[7]);
    push_entry.degen = (prod_r[0] == prod_r[1]);
  end

endmodule

// ===== rtl/b2v_fifo.sv =====
// Short queue that decouples the front end from the divide pipeline.
`timescale 1ns / 1ps
module b2v_fifo (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  b2v_pkg::b2v_entry_t      push_entry,
  input  logic                     pop,
  output b2v_pkg::b2v_entry_t      head_entry,
  output b2v_pkg::b2v_fifo_stat_t  fifo_stat
);
  import b2v_pkg::*;

  b2v_entry_t       mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign fifo_stat.full  = (count_r == CNT_W'(FIFO_DEPTH));
  assign fifo_stat.empty = (count_r == '0);
  assign head_entry      = mem_r[rd_ptr_r];

  // Store the incoming entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  // Advance pointers and track occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (!push && pop) count_r <= count_r - 1'b1;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !fifo_stat.full) else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !fifo_stat.empty) else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(FIFO_DEPTH)) else $error("queue count beyond depth");

endmodule

// ===== rtl/b2v_back.sv =====
// Back end: pipelined restoring division of the three weights, saturation and checks.
`timescale 1ns / 1ps
module b2v_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [b2v_pkg::TOL_W-1:0]     tolerance,
  input  b2v_pkg::b2v_fifo_stat_t       fifo_stat,
  input  b2v_pkg::b2v_entry_t           head_entry,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [31:0]            out_weight_a,
  output logic signed [31:0]            out_weight_b,
  output logic signed [31:0]            out_weight_c,
  output logic                          out_inside_res,
  output logic [31:0]                   out_excess_error,
  output logic                          out_degenerate
);
  import b2v_pkg::*;

  localparam int NW = CROSS_W + FRAC_BITS + 1;
  localparam int DW = CROSS_W + QB;
  localparam int RW = (NW > DW) ? NW : DW;

  function automatic logic [CROSS_W-1:0] mag(input logic signed [CROSS_W-1:0] v);
    return v[CROSS_W-1] ? CROSS_W'(-v) : CROSS_W'(v);
  endfunction

  logic en;

  // Operand magnitudes stage
  logic               b0_vld_r, b0_degen_r;
  logic [2:0]         b0_neg_r;
  logic [CROSS_W-1:0] b0_md_r;
  logic [CROSS_W-1:0] b0_mn_r [3];

  // Division pipeline; index 0 holds the scaled dividend
  logic [RW-1:0]      rem_r   [QB+1][3];
  logic [QB-1:0]      q_r     [QB+1][3];
  logic [CROSS_W-1:0] md_r    [QB+1];
  logic [2:0]         neg_r   [QB+1];
  logic [2:0]         ovf_r   [QB+1];
  logic               degen_r [QB+1];
  logic               vld_r   [QB+1];

  // Saturation and check stages
  logic               s1_vld_r, s1_degen_r;
  logic signed [31:0] s1_w_r [3];
  logic               s2_vld_r, s2_degen_r, s2_inside_r;
  logic signed [31:0] s2_w_r [3];
  logic [63:0]        s2_sq_r [3];

  // Stall every stage together when the output is held
  assign en  = !out_valid || out_ready;
  assign pop = en && !fifo_stat.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) b0_vld_r <= 1'b0;
    else if (en) b0_vld_r <= !fifo_stat.empty;
  end

  // Split signs and magnitudes
  always_ff @(posedge clk) begin
    if (en) begin
      b0_degen_r <= head_entry.degen;
      b0_md_r    <= mag(head_entry.det);
      b0_mn_r[0] <= mag(head_entry.num_a);
      b0_mn_r[1] <= mag(head_entry.num_b);
      b0_mn_r[2] <= mag(head_entry.num_c);
      b0_neg_r   <= {head_entry.num_c[CROSS_W-1] ^ head_entry.det[CROSS_W-1],
                     head_entry.num_b[CROSS_W-1] ^ head_entry.det[CROSS_W-1],
                     head_entry.num_a[CROSS_W-1] ^ head_entry.det[CROSS_W-1]};
    end
  end

  // Scale, add half the divisor for rounding, flag quotients too wide
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r[0] <= 1'b0;
    else if (en) vld_r[0] <= b0_vld_r;
  end

  always_ff @(posedge clk) begin
    logic [RW-1:0] n;
    if (en) begin
      md_r[0]    <= b0_md_r;
      neg_r[0]   <= b0_neg_r;
      degen_r[0] <= b0_degen_r;
      for (int j = 0; j < 3; j++) begin
        n = (RW'(b0_mn_r[j]) << FRAC_BITS) + RW'(b0_md_r >> 1);
        rem_r[0][j] <= n;
        q_r[0][j]   <= '0;
        ovf_r[0][j] <= (n >= (RW'(b0_md_r) << QB));
      end
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar k = 0; k < QB; k++) begin : g_div
    logic [RW-1:0] ds;
    assign ds = RW'(md_r[k]) << (QB - 1 - k);

    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[k+1] <= 1'b0;
      else if (en) vld_r[k+1] <= vld_r[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        md_r[k+1]    <= md_r[k];
        neg_r[k+1]   <= neg_r[k];
        ovf_r[k+1]   <= ovf_r[k];
        degen_r[k+1] <= degen_r[k];
        for (int j = 0; j < 3; j++) begin
          if (rem_r[k][j] >= ds) begin
            rem_r[k+1][j] <= rem_r[k][j] - ds;
            q_r[k+1][j]   <= {q_r[k][j][QB-2:0], 1'b1};
          end else begin
            rem_r[k+1][j] <= rem_r[k][j];
            q_r[k+1][j]   <= {q_r[k][j][QB-2:0], 1'b0};
          end
        end
      end
    end
  end

  // Apply sign and saturate to 32 bits
  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else if (en) s1_vld_r <= vld_r[QB];
  end

  always_ff @(posedge clk) begin
    logic [QB-1:0] q;
    if (en) begin
      s1_degen_r <= degen_r[QB];
      for (int j = 0; j < 3; j++) begin
        q = q_r[QB][j];
        if (!neg_r[QB][j]) begin
          if (ovf_r[QB][j] || q > QB'(32'h7FFF_FFFF)) s1_w_r[j] <= 32'sh7FFF_FFFF;
          else                                        s1_w_r[j] <= $signed(q[31:0]);
        end else begin
          if (ovf_r[QB][j] || q > QB'(32'h8000_0000)) s1_w_r[j] <= 32'sh8000_0000;
          else                                        s1_w_r[j] <= $signed(32'(-q));
        end
      end
    end
  end

  // Range and sum checks, square the excess
  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else if (en) s2_vld_r <= s1_vld_r;
  end

  always_ff @(posedge clk) begin
    logic signed [35:0] one, eps, w, e, sum;
    logic [31:0] eu;
    logic ok;
    if (en) begin
      one = 36'sd1 <<< FRAC_BITS;
      eps = $signed(36'(tolerance));
      ok  = 1'b1;
      sum = -one;
      for (int j = 0; j < 3; j++) begin
        w = 36'(s1_w_r[j]);
        if (w < -eps || w > one + eps) ok = 1'b0;
        if (w < 0)        e = -w;
        else if (w > one) e = w - one;
        else              e = '0;
        eu = e[31:0];
        s2_sq_r[j] <= eu * eu;
        sum = sum + w;
      end
      if (sum < 0) sum = -sum;
      if (!(sum < eps)) ok = 1'b0;
      s2_inside_r <= ok;
      s2_degen_r  <= s1_degen_r;
      s2_w_r      <= s1_w_r;
    end
  end

  // Output register: sum squares, rescale, saturate; zero degenerate items
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (en) out_valid <= s2_vld_r;
  end

  always_ff @(posedge clk) begin
    logic [65:0] tot;
    if (en) begin
      tot = (66'(s2_sq_r[0]) + 66'(s2_sq_r[1]) + 66'(s2_sq_r[2])) >> FRAC_BITS;
      if (s2_degen_r) begin
        out_weight_a     <= '0;
        out_weight_b     <= '0;
        out_weight_c     <= '0;
        out_inside_res   <= 1'b0;
        out_excess_error <= '0;
      end else begin
        out_weight_a     <= s2_w_r[0];
        out_weight_b     <= s2_w_r[1];
        out_weight_c     <= s2_w_r[2];
        out_inside_res   <= s2_inside_r;
        out_excess_error <= (|tot[65:32]) ? 32'hFFFF_FFFF : tot[31:0];
      end
      out_degenerate <= s2_degen_r;
    end
  end

endmodule

// ===== rtl/barycentric_2d_with_validity.sv =====
// Top level of the 2D barycentric weight block with inside and degenerate checks.
`timescale 1ns / 1ps
// Usage:
//  - Input channel in_*: valid/ready; one transaction carries three triangle
//    vertices and a query point, signed fixed point with FRAC_BITS fraction bits.
//  - Output channel out_*: valid/ready; one transaction per input with three
//    saturated weights, inside flag, squared excess and degenerate flag.
//  - cfg_we/cfg_wdata write the tolerance register (reset value 7); write it
//    only while no transaction is in flight.
//  - Throughput: one transaction per cycle unless out_ready holds the output or
//    the queue fills. Stages: two front stages (edge vectors, cross products),
//    the queue, two operand stages, 33 restoring divide stages (one quotient
//    bit each), and three saturation/check/output stages.
//  - Reset (synchronous, rst_n low) empties the pipeline and queue and restores
//    the tolerance.
//  - When out_valid is high and out_ready low the divide pipeline holds; the front end keeps
//    accepting until the four-entry queue fills, then drops in_ready.
module barycentric_2d_with_validity #(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [31:0]           in_vert_a_s,
  input  logic signed [31:0]           in_vert_a_t,
  input  logic signed [31:0]           in_vert_b_s,
  input  logic signed [31:0]           in_vert_b_t,
  input  logic signed [31:0]           in_vert_c_s,
  input  logic signed [31:0]           in_vert_c_t,
  input  logic signed [31:0]           in_point_s,
  input  logic signed [31:0]           in_point_t,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [31:0]           out_weight_a,
  output logic signed [31:0]           out_weight_b,
  output logic signed [31:0]           out_weight_c,
  output logic                         out_inside_res,
  output logic [31:0]                  out_excess_error,
  output logic                         out_degenerate,
  input  logic                         cfg_we,
  input  logic [b2v_pkg::TOL_W-1:0]    cfg_wdata
);
  import b2v_pkg::*;

  logic [TOL_W-1:0] tolerance_r;
  logic             push, pop;
  b2v_entry_t       push_entry, head_entry;
  b2v_fifo_stat_t   fifo_stat;

  // Tolerance register
  always_ff @(posedge clk) begin
    if (!rst_n) tolerance_r <= TOL_W'(7);
    else if (cfg_we) tolerance_r <= cfg_wdata;
  end

  b2v_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_vert_a_s (in_vert_a_s),
    .in_vert_a_t (in_vert_a_t),
    .in_vert_b_s (in_vert_b_s),
    .in_vert_b_t (in_vert_b_t),
    .in_vert_c_s (in_vert_c_s),
    .in_vert_c_t (in_vert_c_t),
    .in_point_s  (in_point_s),
    .in_point_t  (in_point_t),
    .fifo_stat   (fifo_stat),
    .push        (push),
    .push_entry  (push_entry)
  );

  b2v_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head_entry (head_entry),
    .fifo_stat  (fifo_stat)
  );

  b2v_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .tolerance        (tolerance_r),
    .fifo_stat        (fifo_stat),
    .head_entry       (head_entry),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_weight_a     (out_weight_a),
    .out_weight_b     (out_weight_b),
    .out_weight_c     (out_weight_c),
    .out_inside_res   (out_inside_res),
    .out_excess_error (out_excess_error),
    .out_degenerate   (out_degenerate)
  );

endmodule

// ===== test/barycentric_2d_with_validity_checker.sv =====
// Checker for the barycentric block: predicts each result and compares it on the output channel.
`timescale 1ns / 1ps
module barycentric_2d_with_validity_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic signed [31:0]        in_vert_a_s,
  input  logic signed [31:0]        in_vert_a_t,
  input  logic signed [31:0]        in_vert_b_s,
  input  logic signed [31:0]        in_vert_b_t,
  input  logic signed [31:0]        in_vert_c_s,
  input  logic signed [31:0]        in_vert_c_t,
  input  logic signed [31:0]        in_point_s,
  input  logic signed [31:0]        in_point_t,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic signed [31:0]        out_weight_a,
  input  logic signed [31:0]        out_weight_b,
  input  logic signed [31:0]        out_weight_c,
  input  logic                      out_inside_res,
  input  logic [31:0]               out_excess_error,
  input  logic                      out_degenerate,
  input  logic                      cfg_we,
  input  logic [b2v_pkg::TOL_W-1:0] cfg_wdata,
  output int                        fail_count,
  output int                        pending_count
);
  localparam int FRAC = 16;
  localparam longint ONE = longint'(1) << FRAC;

  typedef struct {
    logic signed [31:0] wa, wb, wc;
    logic               contained;
    logic [31:0]        excess;
    logic               degen;
  } weights_t;

  weights_t expected_weights[$];
  logic [b2v_pkg::TOL_W-1:0] tol_copy;

  // x1*y2 - x2*y1 at full width
  function automatic logic signed [127:0] cross_area(input longint x1, input longint y1,
                                                     input longint x2, input longint y2);
    logic signed [127:0] a, b, c, d;
    a = x1; b = y2; c = x2; d = y1;
    return a * b - c * d;
  endfunction

  // round(num * ONE / den), ties away from zero, saturated to 32-bit signed
  function automatic longint scaled_quotient(input logic signed [127:0] num,
                                             input logic signed [127:0] den);
    logic [127:0] mn, md, q;
    logic         neg;
    neg = num[127] ^ den[127];
    mn = num[127] ? -num : num;
    md = den[127] ? -den : den;
    q = ((mn << FRAC) + (md >> 1)) / md;
    if (!neg) return (q > 128'h7FFF_FFFF) ? 64'sd2147483647 : longint'(q);
    return (q > 128'h8000_0000) ? -64'sd2147483648 : -longint'(q);
  endfunction

  function automatic weights_t solve_weights(input logic [b2v_pkg::TOL_W-1:0] tol);
    longint as, at, bs, bt, cs, ct, ps, pt, eps, sum, e;
    longint w[3];
    logic signed [127:0] det;
    logic [65:0] sq;
    weights_t r;
    as = in_vert_a_s; at = in_vert_a_t; bs = in_vert_b_s; bt = in_vert_b_t;
    cs = in_vert_c_s; ct = in_vert_c_t; ps = in_point_s;  pt = in_point_t;
    eps = tol;
    det = cross_area(bs - as, bt - at, cs - as, ct - at);
    r.wa = 0; r.wb = 0; r.wc = 0; r.contained = 0; r.excess = 0; r.degen = 1;
    if (det == 0) return r;
    w[0] = scaled_quotient(cross_area(bs - ps, bt - pt, cs - ps, ct - pt), det);
    w[1] = scaled_quotient(cross_area(cs - ps, ct - pt, as - ps, at - pt), det);
    w[2] = scaled_quotient(cross_area(as - ps, at - pt, bs - ps, bt - pt), det);
    r.contained = 1;
    sq = 0;
    for (int k = 0; k < 3; k++) begin
      if (w[k] < -eps || w[k] > ONE + eps) r.contained = 0;
      e = (w[k] < 0) ? -w[k] : (w[k] > ONE) ? w[k] - ONE : 0;
      sq += 66'(e) * 66'(e);
    end
    sum = w[0] + w[1] + w[2] - ONE;
    if (sum < 0) sum = -sum;
    if (!(sum < eps)) r.contained = 0;
    sq = sq >> FRAC;
    r.excess = (sq > 66'hFFFF_FFFF) ? 32'hFFFF_FFFF : sq[31:0];
    r.wa = w[0][31:0]; r.wb = w[1][31:0]; r.wc = w[2][31:0];
    r.degen = 0;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending_count = 0;
  end

  always @(posedge clk) begin
    weights_t x;
    if (!rst_n) begin
      tol_copy <= 16'd7;
    end else begin
      // track the tolerance register
      if (cfg_we) tol_copy <= cfg_wdata;
      // predict each accepted transaction
      if (in_valid && in_ready) expected_weights.push_back(solve_weights(tol_copy));
      // compare each delivered result with the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_weights.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          x = expected_weights.pop_front();
          if (out_weight_a !== x.wa) report_mismatch("weight_a", out_weight_a, x.wa);
          if (out_weight_b !== x.wb) report_mismatch("weight_b", out_weight_b, x.wb);
          if (out_weight_c !== x.wc) report_mismatch("weight_c", out_weight_c, x.wc);
          if (out_inside_res !== x.contained)
            report_mismatch("inside_res", out_inside_res, x.contained);
          if (out_excess_error !== x.excess)
            report_mismatch("excess_error", out_excess_error, x.excess);
          if (out_degenerate !== x.degen)
            report_mismatch("degenerate", out_degenerate, x.degen);
        end
      end
    end
    pending_count <= expected_weights.size();
  end
endmodule

// ===== test/barycentric_2d_with_validity_test.sv =====
// Stimulus and verdict for the barycentric block, with the checker beside it.
`timescale 1ns / 1ps
module barycentric_2d_with_validity_test;
  localparam longint CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 60;
  localparam int ONE = 1 << 16;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_ready;
  logic signed [31:0] in_vert_a_s = 0, in_vert_a_t = 0, in_vert_b_s = 0, in_vert_b_t = 0;
  logic signed [31:0] in_vert_c_s = 0, in_vert_c_t = 0, in_point_s = 0, in_point_t = 0;
  logic out_valid, out_ready = 0;
  logic signed [31:0] out_weight_a, out_weight_b, out_weight_c;
  logic out_inside_res, out_degenerate;
  logic [31:0] out_excess_error;
  logic cfg_we = 0;
  logic [b2v_pkg::TOL_W-1:0] cfg_wdata = 0;
  int fail_count, pending_count;
  longint cycles = 0;
  bit steady = 0;

  barycentric_2d_with_validity uut (.*);
  barycentric_2d_with_validity_checker chk (.*);

  // clock
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // count cycles and stop on a hang
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver stalls, except during the steady stretch
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 11);
  end

  function automatic int near(input int r);
    return int'($urandom_range(2 * r)) - r;
  endfunction

  // drive one transaction and hold it until accepted
  task automatic send(input int as, at, bs, bt, cs, ct, ps, pt);
    if (!steady && $urandom_range(99) < 11) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1;
    in_vert_a_s <= as; in_vert_a_t <= at; in_vert_b_s <= bs; in_vert_b_t <= bt;
    in_vert_c_s <= cs; in_vert_c_t <= ct; in_point_s <= ps; in_point_t <= pt;
    do @(posedge clk); while (!in_ready);
  endtask

  // hold off until every result is back and the pipeline is empty
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_tolerance(input logic [15:0] v);
    drain();
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic random_item();
    int kind, as, at, bs, bt, cs, ct, k, r;
    kind = $urandom_range(99);
    r = 1 << $urandom_range(4, 22);
    as = near(r); at = near(r); bs = near(r); bt = near(r); cs = near(r); ct = near(r);
    if (kind < 50) begin
      // well-formed triangle, point near it
      send(as, at, bs, bt, cs, ct, (as + bs + cs) / 3 + near(r / 2), (at + bt + ct) / 3 + near(r / 2));
    end else if (kind < 70) begin
      send($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else if (kind < 85) begin
      // collinear or repeated vertices
      k = near(3);
      if ($urandom_range(1)) send(as, at, bs, bt, as + k * (bs - as), at + k * (bt - at), near(r), near(r));
      else send(as, at, as, at, cs, ct, near(r), near(r));
    end else begin
      // tiny triangle, far point: saturating weights
      send(as, at, as + 1, at, as, at + $urandom_range(1, 3), $urandom, $urandom);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed cases at the reset tolerance
    send(0, 0, ONE, 0, 0, ONE, ONE / 3, ONE / 3);
    send(0, 0, ONE, 0, 0, ONE, 0, 0);
    send(0, 0, ONE, 0, 0, ONE, ONE, 0);
    send(0, 0, ONE, 0, 0, ONE, ONE / 2, ONE / 2);
    send(0, 0, ONE, 0, 0, ONE, 2 * ONE, 2 * ONE);
    send(0, 0, 0, 0, 0, 0, 0, 0);
    send(0, 0, ONE, ONE, 2 * ONE, 2 * ONE, ONE, 0);
    send(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
         32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
    send(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
         32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send(0, 0, 1, 0, 0, 1, 32'h7FFF_FFFF, 32'h8000_0000);
    send(0, 0, 1, 0, 0, 1, 32'h8000_0000, 32'h8000_0000);
    send(0, 0, 0, 1, 1, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send(-1, -1, -1, -1, -1, -1, -1, -1);
    send(0, 0, 3, 0, 0, 3, 1, 1);
    send(0, 0, 2, 0, 0, 2, 1, 0);

    // tolerance sweep: directed cases in the first phases, random traffic in the later ones
    write_tolerance(16'd0);
    send(0, 0, ONE, 0, 0, ONE, ONE / 4, ONE / 4);
    send(0, 0, 3 * ONE, 0, 0, 3 * ONE, ONE, ONE);
    write_tolerance(16'hFFFF);
    send(0, 0, ONE, 0, 0, ONE, ONE, ONE);
    send(0, 0, ONE, 0, 0, ONE, -ONE / 2, 0);
    write_tolerance(16'd1);
    for (int i = 0; i < 300; i++) random_item();
    write_tolerance(16'd3);
    for (int i = 0; i < 400; i++) random_item();
    // steady stretch with no idling on either side
    steady = 1;
    for (int i = 0; i < 300; i++) random_item();
    steady = 0;
    write_tolerance(16'($urandom));
    for (int i = 0; i < 300; i++) random_item();
    write_tolerance(16'hFFFF);
    for (int i = 0; i < 200; i++) random_item();
    write_tolerance(16'd0);
    for (int i = 0; i < 200; i++) random_item();

    drain();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/b2v_pkg.sv
rtl/b2v_front.sv
rtl/b2v_fifo.sv
rtl/b2v_back.sv
rtl/barycentric_2d_with_validity.sv
test/barycentric_2d_with_validity_checker.sv
test/barycentric_2d_with_validity_test.sv
